[hw/rtl/ps2_scancode_to_ascii_unit_assert.svh]
// ----------------------------------------------------------------------------
// ps2 scancode decoder assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PS2SA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2sa assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PS2SA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2sa assertion failed");

`endif

[hw/rtl/ps2sa_pkg.sv]
// ----------------------------------------------------------------------------
// ps2sa_pkg
// types, scancode constants and character tables of the ps2 scancode decoder
// ----------------------------------------------------------------------------
package ps2sa_pkg;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_CMD    = 2'd2;

    // special scancodes
    localparam logic [7:0] SC_NONE      = 8'h00;
    localparam logic [7:0] SC_SELF_TEST = 8'hAA;
    localparam logic [7:0] SC_EXTENDED  = 8'hE0;
    localparam logic [7:0] SC_BREAK     = 8'hF0;
    localparam logic [7:0] SC_LSHIFT    = 8'h12;
    localparam logic [7:0] SC_RSHIFT    = 8'h59;
    localparam logic [7:0] SC_CTRL      = 8'h14;
    localparam logic [7:0] SC_ALT       = 8'h11;
    localparam logic [7:0] SC_NUM_LOCK  = 8'h77;
    localparam logic [7:0] SC_CAPS_LOCK = 8'h58;
    localparam logic [7:0] SC_SCRL_LOCK = 8'h7E;

    // keyboard command to set the leds
    localparam logic [7:0] CMD_SET_LEDS = 8'hED;

    // lowercase letter range and case offset
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;

    typedef struct packed {
        logic break_pending;
        logic extended_pending;
        logic shift_held;
        logic ctrl_held;
        logic alt_held;
        logic caps_lock;
        logic num_lock;
        logic scroll_lock;
        logic lock_key_held;
        logic self_test_flag;
    } t_state;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] out_byte;
        logic       last_item;
        logic       shift_down;
        logic       ctrl_down;
        logic       alt_down;
        logic       caps_on;
        logic       num_on;
        logic       scroll_on;
        logic       self_test_seen;
    } t_result;

    // unshifted table
    function automatic logic [7:0] f_plain_char(input logic [7:0] sc);
        logic [7:0] ch;
        ch = 8'h00;
        case (sc)
            8'h7c: ch = "*";
            8'h7b: ch = "-";
            8'h79: ch = "+";
            8'h70: ch = "0";
            8'h69: ch = "1";
            8'h7a: ch = "3";
            8'h73: ch = "5";
            8'h6c: ch = "7";
            8'h7d: ch = "9";
            8'h71: ch = ".";
            8'h75: ch = 8'h11;
            8'h72: ch = 8'h12;
            8'h6b: ch = 8'h13;
            8'h74: ch = 8'h14;
            8'h1c: ch = "a";
            8'h32: ch = "b";
            8'h21: ch = "c";
            8'h23: ch = "d";
            8'h24: ch = "e";
            8'h2b: ch = "f";
            8'h34: ch = "g";
            8'h33: ch = "h";
            8'h43: ch = "i";
            8'h3b: ch = "j";
            8'h42: ch = "k";
            8'h4b: ch = "l";
            8'h3a: ch = "m";
            8'h31: ch = "n";
            8'h44: ch = "o";
            8'h4d: ch = "p";
            8'h15: ch = "q";
            8'h2d: ch = "r";
            8'h1b: ch = "s";
            8'h2c: ch = "t";
            8'h3c: ch = "u";
            8'h2a: ch = "v";
            8'h1d: ch = "w";
            8'h22: ch = "x";
            8'h35: ch = "y";
            8'h1a: ch = "z";
            8'h45: ch = "0";
            8'h16: ch = "1";
            8'h1e: ch = "2";
            8'h26: ch = "3";
            8'h25: ch = "4";
            8'h2e: ch = "5";
            8'h36: ch = "6";
            8'h3d: ch = "7";
            8'h3e: ch = "8";
            8'h46: ch = "9";
            8'h29: ch = 8'h20;
            8'h5a: ch = 8'h0d;
            8'h66: ch = 8'h08;
            8'h0d: ch = 8'h09;
            8'h54: ch = "[";
            8'h5b: ch = "]";
            8'h4e: ch = "-";
            8'h55: ch = "=";
            8'h4c: ch = ";";
            8'h52: ch = 8'h27;
            8'h0e: ch = 8'h60;
            8'h41: ch = ",";
            8'h49: ch = ".";
            8'h5d: ch = 8'h5c;
            8'h4a: ch = "/";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // shifted table
    function automatic logic [7:0] f_shift_char(input logic [7:0] sc);
        logic [7:0] ch;
        ch = 8'h00;
        case (sc)
            8'h1c: ch = "A";
            8'h32: ch = "B";
            8'h21: ch = "C";
            8'h23: ch = "D";
            8'h24: ch = "E";
            8'h2b: ch = "F";
            8'h34: ch = "G";
            8'h33: ch = "H";
            8'h43: ch = "I";
            8'h3b: ch = "J";
            8'h42: ch = "K";
            8'h4b: ch = "L";
            8'h3a: ch = "M";
            8'h31: ch = "N";
            8'h44: ch = "O";
            8'h4d: ch = "P";
            8'h15: ch = "Q";
            8'h2d: ch = "R";
            8'h1b: ch = "S";
            8'h2c: ch = "T";
            8'h3c: ch = "U";
            8'h2a: ch = "V";
            8'h1d: ch = "W";
            8'h22: ch = "X";
            8'h35: ch = "Y";
            8'h1a: ch = "Z";
            8'h45: ch = ")";
            8'h16: ch = "!";
            8'h1e: ch = "@";
            8'h26: ch = "#";
            8'h25: ch = "$";
            8'h2e: ch = "%";
            8'h36: ch = "^";
            8'h3d: ch = "&";
            8'h3e: ch = "*";
            8'h46: ch = "(";
            8'h29: ch = 8'h20;
            8'h5a: ch = 8'h0d;
            8'h66: ch = 8'h08;
            8'h54: ch = "{";
            8'h5b: ch = "}";
            8'h4e: ch = "_";
            8'h55: ch = "+";
            8'h4c: ch = ":";
            8'h52: ch = 8'h22;
            8'h0e: ch = "~";
            8'h41: ch = "<";
            8'h49: ch = ">";
            8'h5d: ch = "|";
            8'h4a: ch = "?";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // keypad arrows when num lock is on
    function automatic logic [7:0] f_num_char(input logic [7:0] sc);
        logic [7:0] ch;
        ch = 8'h00;
        case (sc)
            8'h75: ch = "8";
            8'h72: ch = "2";
            8'h6b: ch = "4";
            8'h74: ch = "6";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // extended codes that carry a character
    function automatic logic [7:0] f_ext_char(input logic [7:0] sc);
        logic [7:0] ch;
        ch = 8'h00;
        case (sc)
            8'h4a: ch = "/";
            8'h5a: ch = 8'h0d;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/ps2sa_in_if.sv]
// ----------------------------------------------------------------------------
// ps2sa_in_if
// valid/ready channel that carries one scancode byte per word
// ----------------------------------------------------------------------------
interface ps2sa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

[hw/rtl/ps2sa_out_if.sv]
// ----------------------------------------------------------------------------
// ps2sa_out_if
// valid/ready channel that carries one decoded result per word
// ----------------------------------------------------------------------------
interface ps2sa_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] out_byte;
    logic       last_item;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
    logic       caps_on;
    logic       num_on;
    logic       scroll_on;
    logic       self_test_seen;

    modport source (
        output valid, output item_kind, output out_byte, output last_item,
        output shift_down, output ctrl_down, output alt_down, output caps_on,
        output num_on, output scroll_on, output self_test_seen, input ready
    );
    modport sink (
        input valid, input item_kind, input out_byte, input last_item,
        input shift_down, input ctrl_down, input alt_down, input caps_on,
        input num_on, input scroll_on, input self_test_seen, output ready
    );
endinterface

[hw/rtl/ps2_scancode_to_ascii_unit.sv]
// an accepted scancode word is held in the decode register; its result word is registered in r_o when decode retires
// throughput: one scancode per cycle while each gives one result word and the output side is ready
// a lock toggle gives two words (led command, then mask); the next scancode waits in
// decode until the single output register has taken the queued second word
// reset (i_rst_n low, synchronous) empties the pipeline and makes the state
// memory read as all-zero until its first write; no clearing sweep is needed
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_unit
// ps2 set 2 scancode to ascii decoder with modifier, lock and led tracking
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ps2sa_in_if.sink    i_scan,
    ps2sa_out_if.source o_res
);
    import ps2sa_pkg::*;

    // keyboard state word lives in a one-entry synchronous memory
    t_state     r_state_mem [0:0];
    logic       r_mem_valid;     // entry written since reset, else reads as zero
    t_state     r_rd_state;      // registered read data (with forwarding)

    // decode stage: holds the accepted scancode word
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;

    // output register and the queued second word of a led command
    logic       r_o_valid;
    t_result    r_o;
    logic       r_second_valid;
    t_result    r_second;

    t_state     n_state;
    logic [7:0] w_char;
    logic [7:0] w_lookup;
    logic       w_toggled;
    logic       w_zero;
    logic       w_in_fire;
    logic       w_out_fire;
    logic       w_s1_fire;
    t_result    w_first;
    t_result    w_mask_item;
    t_state     w_mem_rd;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign w_out_fire = r_o_valid && o_res.ready;
    // decode retires when the output side can take its word(s); a pending
    // second led word blocks until it has moved to the output register
    assign w_s1_fire  = r_s1_valid && !r_second_valid && (!r_o_valid || o_res.ready);
    assign i_scan.ready = !r_s1_valid || w_s1_fire;
    assign w_in_fire  = i_scan.valid && i_scan.ready;

    assign w_mem_rd = r_mem_valid ? r_state_mem[0] : '0;

    // ------------------------------------------------------------------
    // decode: read-modify of the state word
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_rd_state;
        w_char    = 8'h00;
        w_lookup  = 8'h00;
        w_toggled = 1'b0;
        w_zero    = (r_s1_byte == SC_NONE);

        if (w_zero) begin
            // idle byte from the line, dropped without any effect
            n_state = r_rd_state;
        end else if (r_s1_byte == SC_SELF_TEST) begin
            n_state.self_test_flag = 1'b1;
        end else if (r_s1_byte == SC_EXTENDED) begin
            n_state.extended_pending = 1'b1;
        end else if (r_s1_byte == SC_BREAK) begin
            n_state.break_pending = 1'b1;
        end else if (r_rd_state.break_pending) begin
            // key release
            n_state.break_pending    = 1'b0;
            n_state.extended_pending = 1'b0;
            if (r_s1_byte == SC_LSHIFT || r_s1_byte == SC_RSHIFT) begin
                n_state.shift_held = 1'b0;
            end else if (r_s1_byte == SC_CTRL) begin
                n_state.ctrl_held = 1'b0;
            end else if (r_s1_byte == SC_ALT) begin
                n_state.alt_held = 1'b0;
            end else if (r_s1_byte == SC_NUM_LOCK || r_s1_byte == SC_CAPS_LOCK ||
                         r_s1_byte == SC_SCRL_LOCK) begin
                n_state.lock_key_held = 1'b0;
            end
        end else if (r_rd_state.extended_pending) begin
            // extended make: right ctrl/alt or keypad slash/enter
            n_state.extended_pending = 1'b0;
            if (r_s1_byte == SC_CTRL) begin
                n_state.ctrl_held = 1'b1;
            end else if (r_s1_byte == SC_ALT) begin
                n_state.alt_held = 1'b1;
            end else begin
                w_char = f_ext_char(r_s1_byte);
            end
        end else if (r_s1_byte == SC_LSHIFT || r_s1_byte == SC_RSHIFT) begin
            n_state.shift_held = 1'b1;
        end else if (r_s1_byte == SC_CTRL) begin
            n_state.ctrl_held = 1'b1;
        end else if (r_s1_byte == SC_ALT) begin
            n_state.alt_held = 1'b1;
        end else if (r_s1_byte == SC_NUM_LOCK && !r_rd_state.lock_key_held) begin
            n_state.num_lock      = !r_rd_state.num_lock;
            n_state.lock_key_held = 1'b1;
            w_toggled             = 1'b1;
        end else if (r_s1_byte == SC_CAPS_LOCK && !r_rd_state.lock_key_held) begin
            n_state.caps_lock     = !r_rd_state.caps_lock;
            n_state.lock_key_held = 1'b1;
            w_toggled             = 1'b1;
        end else if (r_s1_byte == SC_SCRL_LOCK && !r_rd_state.lock_key_held) begin
            n_state.scroll_lock   = !r_rd_state.scroll_lock;
            n_state.lock_key_held = 1'b1;
            w_toggled             = 1'b1;
        end else begin
            // table priority: shifted, then num lock keypad, then plain
            if (r_rd_state.shift_held) begin
                w_lookup = f_shift_char(r_s1_byte);
            end
            if (w_lookup == 8'h00 && r_rd_state.num_lock) begin
                w_lookup = f_num_char(r_s1_byte);
            end
            if (w_lookup == 8'h00) begin
                w_lookup = f_plain_char(r_s1_byte);
                if ((r_rd_state.shift_held != r_rd_state.caps_lock) &&
                    w_lookup >= CH_LOWER_A && w_lookup <= CH_LOWER_Z) begin
                    w_lookup = w_lookup - CH_CASE_OFS;
                end
            end
            w_char = w_lookup;
        end
    end

    // result words carry the state after this scancode
    always_comb begin
        w_first.shift_down     = n_state.shift_held;
        w_first.ctrl_down      = n_state.ctrl_held;
        w_first.alt_down       = n_state.alt_held;
        w_first.caps_on        = n_state.caps_lock;
        w_first.num_on         = n_state.num_lock;
        w_first.scroll_on      = n_state.scroll_lock;
        w_first.self_test_seen = n_state.self_test_flag;

        if (w_toggled) begin
            w_first.item_kind = KIND_CMD;
            w_first.out_byte  = CMD_SET_LEDS;
            w_first.last_item = 1'b0;
        end else if (w_char != 8'h00) begin
            w_first.item_kind = KIND_CHAR;
            w_first.out_byte  = w_char;
            w_first.last_item = 1'b1;
        end else begin
            w_first.item_kind = KIND_STATUS;
            w_first.out_byte  = 8'h00;
            w_first.last_item = 1'b1;
        end

        // led mask: caps, num, scroll from high to low
        w_mask_item = w_first;
        w_mask_item.item_kind = KIND_CMD;
        w_mask_item.out_byte  = {5'b00000, n_state.caps_lock, n_state.num_lock,
                                 n_state.scroll_lock};
        w_mask_item.last_item = 1'b1;
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_mem_valid    <= 1'b0;
            r_o_valid      <= 1'b0;
            r_second_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_fire) begin
                r_mem_valid <= 1'b1;
            end

            if (w_s1_fire && !w_zero) begin
                r_o_valid      <= 1'b1;
                r_second_valid <= w_toggled;
            end else if (w_out_fire) begin
                if (r_second_valid) begin
                    r_second_valid <= 1'b0;
                end else begin
                    r_o_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers and state memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_byte <= i_scan.scan_byte;
            // forward the write of the retiring word to the next reader
            r_rd_state <= w_s1_fire ? n_state : w_mem_rd;
        end

        if (w_s1_fire) begin
            r_state_mem[0] <= n_state;
        end

        if (w_s1_fire && !w_zero) begin
            r_o      <= w_first;
            r_second <= w_mask_item;
        end else if (w_out_fire && r_second_valid) begin
            r_o <= r_second;
        end
    end

    // ------------------------------------------------------------------
    // output channel
    // ------------------------------------------------------------------
    assign o_res.valid          = r_o_valid;
    assign o_res.item_kind      = r_o.item_kind;
    assign o_res.out_byte       = r_o.out_byte;
    assign o_res.last_item      = r_o.last_item;
    assign o_res.shift_down     = r_o.shift_down;
    assign o_res.ctrl_down      = r_o.ctrl_down;
    assign o_res.alt_down       = r_o.alt_down;
    assign o_res.caps_on        = r_o.caps_on;
    assign o_res.num_on         = r_o.num_on;
    assign o_res.scroll_on      = r_o.scroll_on;
    assign o_res.self_test_seen = r_o.self_test_seen;

endmodule

[hw/rtl/ps2sa_checker.sv]
// ----------------------------------------------------------------------------
// ps2sa_checker
// port-level checks on the result words of the scancode decoder
// ----------------------------------------------------------------------------
`include "ps2_scancode_to_ascii_unit_assert.svh"

module ps2sa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_item_kind,
    input logic [7:0] i_out_byte,
    input logic       i_last_item
);
    import ps2sa_pkg::*;

    // a stalled word stays offered
    `PS2SA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // status-only words carry no byte and close their scancode
    `PS2SA_ASSERT_NOW(a_status_empty, i_clk, i_rst_n, i_out_valid && i_item_kind == KIND_STATUS, i_out_byte == 8'h00 && i_last_item)

    // only the led command opener leaves a scancode open
    `PS2SA_ASSERT_NOW(a_open_is_cmd, i_clk, i_rst_n, i_out_valid && !i_last_item, i_item_kind == KIND_CMD && i_out_byte == CMD_SET_LEDS)

    // the led mask follows its command opener at once
    `PS2SA_ASSERT_NEXT(a_mask_follows, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_item, i_out_valid && i_item_kind == KIND_CMD && i_last_item)

endmodule

bind ps2_scancode_to_ascii_unit ps2sa_checker u_ps2sa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_item_kind (o_res.item_kind),
    .i_out_byte  (o_res.out_byte),
    .i_last_item (o_res.last_item)
);
